/* hdl/necird_pkg.sv */
// shared types and constants for the nec ir pulse decoder
// no dependencies; used by every module under hdl
package necird_pkg;

    // raw stamp difference limits, in 1 us ticks; width w = diff / 10
    // w > n  <=> diff >= 10*(n+1),  w < n  <=> diff < 10*n
    localparam logic [31:0] LEAD_A_LO  = 32'd4010;   // w > 400
    localparam logic [31:0] LEAD_A_HI  = 32'd5000;   // w < 500
    localparam logic [31:0] LEAD_B_LO  = 32'd7010;   // w > 700
    localparam logic [31:0] LEAD_B_HI  = 32'd11000;  // w < 1100
    localparam logic [31:0] HDR_LO     = 32'd3140;   // w > 313
    localparam logic [31:0] HDR_HI     = 32'd6000;   // w < 600
    localparam logic [31:0] REP_LO     = 32'd1510;   // w > 150
    localparam logic [31:0] REP_HI     = 32'd2500;   // w < 250

    // short intervals are divided exactly through a reciprocal
    localparam int unsigned SHORT_BITS  = 12;
    localparam int unsigned WIDTH_BITS  = 9;         // 4095 / 10 fits
    localparam logic [SHORT_BITS-1:0] RECIP_10 = 12'd3277;
    localparam int unsigned RECIP_SHIFT = 15;

    // limits in 10 us units
    localparam logic [WIDTH_BITS-1:0] BIT_LOW_MIN = 9'd10;
    localparam logic [WIDTH_BITS-1:0] BIT_LOW_MAX = 9'd100;
    localparam logic [9:0] ZERO_MIN = 10'd92;
    localparam logic [9:0] ZERO_MAX = 10'd132;
    localparam logic [9:0] ONE_MIN  = 10'd205;
    localparam logic [9:0] ONE_MAX  = 10'd245;

    // configuration
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_OFFSET    = 2'd2;
    localparam logic [7:0] REPEAT_THRESHOLD_RST = 8'd3;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_KEY    = 2'd1,
        EV_REPEAT = 2'd2
    } event_t;

    // one classified interval handed from the input stage to the decoder
    typedef struct packed {
        logic                  valid;
        logic                  skip;       // first edge after reset
        logic                  lead_ok;
        logic                  hdr_ok;
        logic                  rep_ok;
        logic                  short_ok;   // diff below 2^SHORT_BITS
        logic [SHORT_BITS-1:0] diff_lo;
    } interval_t;

    typedef struct packed {
        logic                     repeat_enable;
        logic [7:0]               repeat_threshold;
        logic [7:0]               repeat_key_offset;
    } cfg_t;

endpackage

/* hdl/necird_interval.sv */
// input stage: stamp difference, range classification, input register
// depends on necird_pkg
module necird_interval
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          edge_stamp,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 take,
    output necird_pkg::interval_t info
);

    logic [31:0]           last_stamp_reg;
    logic [31:0]           last_stamp_next;
    logic                  primed_reg;
    logic                  primed_next;
    necird_pkg::interval_t info_reg;
    necird_pkg::interval_t info_next;
    logic [31:0]           diff;
    logic                  in_fire;

    assign in_stall = info_reg.valid && !take;
    assign in_fire  = in_valid && !in_stall;
    assign diff     = edge_stamp - last_stamp_reg;  // wraps modulo 2^32

    always_comb
    begin
        last_stamp_next = last_stamp_reg;
        primed_next     = primed_reg;
        info_next       = info_reg;
        if (take)
        begin
            info_next.valid = 1'b0;
        end
        if (in_fire)
        begin
            last_stamp_next    = edge_stamp;
            primed_next        = 1'b1;
            info_next.valid    = 1'b1;
            info_next.skip     = !primed_reg;
            info_next.lead_ok  = (diff >= necird_pkg::LEAD_A_LO && diff < necird_pkg::LEAD_A_HI)
                              || (diff >= necird_pkg::LEAD_B_LO && diff < necird_pkg::LEAD_B_HI);
            info_next.hdr_ok   = diff >= necird_pkg::HDR_LO && diff < necird_pkg::HDR_HI;
            info_next.rep_ok   = diff >= necird_pkg::REP_LO && diff < necird_pkg::REP_HI;
            info_next.short_ok = diff[31:necird_pkg::SHORT_BITS] == '0;
            info_next.diff_lo  = diff[necird_pkg::SHORT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            primed_reg     <= 1'b0;
            info_reg       <= '0;
        end
        else
        begin
            last_stamp_reg <= last_stamp_next;
            primed_reg     <= primed_next;
            info_reg       <= info_next;
        end
    end

    assign info = info_reg;

endmodule

/* hdl/necird_decode.sv */
// nec frame state machine and result register
// depends on necird_pkg
module necird_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  necird_pkg::interval_t info,
    input  necird_pkg::cfg_t      cfg,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            event_res,
    output logic [7:0]            key_code
);

    typedef enum logic [1:0] {
        PH_LEAD_LOW  = 2'd0,
        PH_LEAD_HIGH = 2'd1,
        PH_BIT_LOW   = 2'd2,
        PH_BIT_HIGH  = 2'd3
    } phase_t;

    localparam int unsigned PROD_BITS = 2 * necird_pkg::SHORT_BITS;
    localparam int unsigned WB        = necird_pkg::WIDTH_BITS;

    phase_t     phase_reg, phase_next;
    logic [6:0] low_time_reg, low_time_next;
    logic [7:0] shift_reg, shift_next;
    logic [5:0] bit_count_reg, bit_count_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] repeat_seen_reg, repeat_seen_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] event_reg, event_next;
    logic [7:0] key_reg, key_next;

    logic [PROD_BITS-1:0] prod;
    logic [WB-1:0]        w;
    logic [9:0]           total;
    logic                 bit_low_ok;
    logic                 zero_ok;
    logic                 one_ok;
    logic [7:0]           shifted;
    logic [5:0]           count_inc;

    assign take = info.valid && (!out_valid_reg || !out_stall);

    // exact divide by 10 for intervals below 4096 ticks
    assign prod  = PROD_BITS'(info.diff_lo) * PROD_BITS'(necird_pkg::RECIP_10);
    assign w     = prod[necird_pkg::RECIP_SHIFT +: WB];
    assign total = {3'b000, low_time_reg} + {1'b0, w};

    // a long interval fails every bit window
    assign bit_low_ok = info.short_ok && w > necird_pkg::BIT_LOW_MIN
                     && w < necird_pkg::BIT_LOW_MAX;
    assign zero_ok = info.short_ok && total > necird_pkg::ZERO_MIN
                  && total < necird_pkg::ZERO_MAX;
    assign one_ok  = info.short_ok && total > necird_pkg::ONE_MIN
                  && total < necird_pkg::ONE_MAX;
    assign shifted   = {one_ok, shift_reg[7:1]};
    assign count_inc = bit_count_reg + 6'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        low_time_next    = low_time_reg;
        shift_next       = shift_reg;
        bit_count_next   = bit_count_reg;
        command_next     = command_reg;
        repeat_seen_next = repeat_seen_reg;
        out_valid_next   = out_valid_reg && out_stall;
        event_next       = event_reg;
        key_next         = key_reg;

        if (take)
        begin
            out_valid_next = 1'b1;
            event_next     = necird_pkg::EV_NONE;
            key_next       = '0;
            if (!info.skip)
            begin
                case (phase_reg)
                    PH_LEAD_LOW:
                    begin
                        if (info.lead_ok)
                        begin
                            phase_next     = PH_LEAD_HIGH;
                            shift_next     = '0;
                            bit_count_next = '0;
                        end
                    end
                    PH_LEAD_HIGH:
                    begin
                        phase_next = PH_LEAD_LOW;
                        if (info.hdr_ok)
                        begin
                            phase_next = PH_BIT_LOW;
                        end
                        else if (info.rep_ok && cfg.repeat_enable)
                        begin
                            if (repeat_seen_reg >= cfg.repeat_threshold)
                            begin
                                event_next = necird_pkg::EV_REPEAT;
                                key_next   = command_reg + cfg.repeat_key_offset;
                            end
                            else
                            begin
                                repeat_seen_next = repeat_seen_reg + 8'd1;
                            end
                        end
                    end
                    PH_BIT_LOW:
                    begin
                        if (bit_low_ok)
                        begin
                            low_time_next = w[6:0];
                            phase_next    = PH_BIT_HIGH;
                        end
                        else if (info.lead_ok)
                        begin
                            // bad width is judged again as a leader low
                            phase_next     = PH_LEAD_HIGH;
                            shift_next     = '0;
                            bit_count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_LEAD_LOW;
                        end
                    end
                    PH_BIT_HIGH:
                    begin
                        shift_next = shifted;
                        if (zero_ok || one_ok)
                        begin
                            bit_count_next = count_inc;
                            phase_next     = PH_BIT_LOW;
                            if (count_inc == 6'd8 || count_inc == 6'd16)
                            begin
                                shift_next = '0;
                            end
                            else if (count_inc == 6'd24)
                            begin
                                command_next = shifted;
                                shift_next   = '0;
                            end
                            else if (count_inc == 6'd32)
                            begin
                                shift_next = '0;
                                phase_next = PH_LEAD_LOW;
                                // inverted command check
                                if (shifted == ~command_reg)
                                begin
                                    repeat_seen_next = '0;
                                    event_next       = necird_pkg::EV_KEY;
                                    key_next         = command_reg;
                                end
                            end
                        end
                        else if (info.lead_ok)
                        begin
                            phase_next     = PH_LEAD_HIGH;
                            shift_next     = '0;
                            bit_count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_LEAD_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEAD_LOW;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD_LOW;
            low_time_reg    <= '0;
            shift_reg       <= '0;
            bit_count_reg   <= '0;
            command_reg     <= '0;
            repeat_seen_reg <= '0;
            out_valid_reg   <= 1'b0;
            event_reg       <= necird_pkg::EV_NONE;
            key_reg         <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            low_time_reg    <= low_time_next;
            shift_reg       <= shift_next;
            bit_count_reg   <= bit_count_next;
            command_reg     <= command_next;
            repeat_seen_reg <= repeat_seen_next;
            out_valid_reg   <= out_valid_next;
            event_reg       <= event_next;
            key_reg         <= key_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign key_code  = key_reg;

endmodule

/* hdl/nec_ir_pulse_decoder_core.sv */
// nec ir pulse decoder top level: configuration registers and stage wiring
// depends on necird_pkg, necird_interval, necird_decode
//
// Each transaction on the input carries a 1 MHz counter stamp taken at one
// edge of the demodulated ir signal, and produces exactly one result
// transaction: event_res 0 (nothing), 1 (new key from a frame whose command
// passed the inverted-command check) or 2 (repeat key, command plus
// repeat_key_offset). The block takes one stamp per clock unless in_stall is
// high: an input register holds the classified interval, and the decoder
// state machine writes the result register from it when that one is free.
// A stamp is still taken while a finished result waits on out_stall;
// only when both registers are full does in_stall rise. The first stamp
// after reset only primes the interval timer and yields event 0.
// Configuration writes are always ready and must be made while idle.
module nec_ir_pulse_decoder_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [31:0]                            edge_stamp,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    output logic [1:0]                             event_res,
    output logic [7:0]                             key_code,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [necird_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [necird_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    necird_pkg::cfg_t      cfg_reg;
    necird_pkg::cfg_t      cfg_next;
    necird_pkg::interval_t info;
    logic                  take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                necird_pkg::CFG_REPEAT_ENABLE:    cfg_next.repeat_enable     = cfg_data[0];
                necird_pkg::CFG_REPEAT_THRESHOLD: cfg_next.repeat_threshold  = cfg_data;
                necird_pkg::CFG_REPEAT_OFFSET:    cfg_next.repeat_key_offset = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_enable     <= 1'b0;
            cfg_reg.repeat_threshold  <= necird_pkg::REPEAT_THRESHOLD_RST;
            cfg_reg.repeat_key_offset <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    necird_interval u_interval
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_stamp (edge_stamp),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .take       (take),
        .info       (info)
    );

    necird_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .info      (info),
        .cfg       (cfg_reg),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .key_code  (key_code)
    );

endmodule
